### hw/rtl/tms_pkg.sv
// Package for the timed mode sequencer: mode, action and event codes,
// configuration defaults and the structs passed between its modules.
// No dependencies.
`default_nettype none

package tms_pkg;

	localparam int CountBitsDef = 32;
	localparam int CfgWidth = 32;
	localparam int CfgIdxWidth = 2;

	typedef enum logic [1:0] {
		MODE_SLEEP   = 2'd0,
		MODE_ARMED   = 2'd1,
		MODE_LOGGING = 2'd2,
		MODE_POSTRUN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_REQUEST = 2'd1,
		ACT_RESTART = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_ENTERED     = 3'd1,
		EV_ARM_BLOCKED = 3'd2,
		EV_NOT_ARMED   = 3'd3,
		EV_NOT_LOGGING = 3'd4,
		EV_TIMEOUT     = 3'd5,
		EV_COOLDOWN    = 3'd6
	} ev_t;

	localparam logic [CfgIdxWidth-1:0] CFG_ARM_TIMEOUT     = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_MAX_LOG_TICKS   = 2'd1;
	localparam logic [CfgIdxWidth-1:0] CFG_COOLDOWN_TICKS  = 2'd2;
	localparam logic [CfgIdxWidth-1:0] CFG_POWER_OFF_TICKS = 2'd3;

	localparam logic [CfgWidth-1:0] ArmTimeoutRst    = 32'd600000;
	localparam logic [CfgWidth-1:0] MaxLogTicksRst   = 32'd600000;
	localparam logic [CfgWidth-1:0] CooldownTicksRst = 32'd5000;
	localparam logic [CfgWidth-1:0] PowerOffTicksRst = 32'd3600000;

	typedef struct packed {
		logic [CfgWidth-1:0] arm_timeout;
		logic [CfgWidth-1:0] max_log_ticks;
		logic [CfgWidth-1:0] cooldown_ticks;
		logic [CfgWidth-1:0] power_off_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		mode_t      target_mode;
		logic       hold_sleep;
		logic       bench_test;
	} item_t;

	typedef struct packed {
		mode_t mode;
		mode_t prev_mode;
		logic  transitioned;
		ev_t   event_res;
		logic  power_off_req;
		logic  arm_allowed;
	} res_t;

endpackage

`default_nettype wire

### hw/rtl/tms_if.sv
// Valid/ready channel interfaces for the timed mode sequencer: one for input
// items and one for result items. No dependencies.
`default_nettype none

interface tms_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] target_mode;
	logic       hold_sleep;
	logic       bench_test;

	modport source (output valid, action, target_mode, hold_sleep, bench_test, input ready);
	modport sink (input valid, action, target_mode, hold_sleep, bench_test, output ready);
endinterface

interface tms_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [1:0] prev_mode;
	logic       transitioned;
	logic [2:0] event_res;
	logic       power_off_req;
	logic       arm_allowed;

	modport source (output valid, mode, prev_mode, transitioned, event_res, power_off_req,
		arm_allowed, input ready);
	modport sink (input valid, mode, prev_mode, transitioned, event_res, power_off_req,
		arm_allowed, output ready);
endinterface

`default_nettype wire

### hw/rtl/tms_cfg_regs.sv
// Configuration register bank of the timed mode sequencer: four time limits.
// Depends on tms_pkg.
`default_nettype none

module tms_cfg_regs
	import tms_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CfgIdxWidth-1:0] cfg_index,
	input  wire logic [CfgWidth-1:0]    cfg_wdata,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_timeout     <= ArmTimeoutRst;
			cfg_q.max_log_ticks   <= MaxLogTicksRst;
			cfg_q.cooldown_ticks  <= CooldownTicksRst;
			cfg_q.power_off_ticks <= PowerOffTicksRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ARM_TIMEOUT:     cfg_q.arm_timeout     <= cfg_wdata;
				CFG_MAX_LOG_TICKS:   cfg_q.max_log_ticks   <= cfg_wdata;
				CFG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= cfg_wdata;
				CFG_POWER_OFF_TICKS: cfg_q.power_off_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/tms_core.sv
// Mode state and transition logic of the timed mode sequencer. Holds the
// mode, elapsed tick counter and rearm flags. Depends on tms_pkg.
`default_nettype none

module tms_core
	import tms_pkg::*;
#(
	parameter int COUNT_BITS = CountBitsDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output res_t       res
);

	localparam int CmpW = (COUNT_BITS > CfgWidth) ? COUNT_BITS : CfgWidth;
	localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

	mode_t                 mode_q, mode_d, enter_mode;
	logic [COUNT_BITS-1:0] elapsed_q, elapsed_d, inc;
	logic                  rearm_ok_q, rearm_ok_d;
	logic                  cooldown_done_q, cooldown_done_d;
	logic                  enter;
	logic                  arm_ok_now;
	logic [CmpW-1:0]       inc_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_SLEEP;
			elapsed_q       <= '0;
			rearm_ok_q      <= 1'b1;
			cooldown_done_q <= 1'b0;
		end else if (en) begin
			mode_q          <= mode_d;
			elapsed_q       <= elapsed_d;
			rearm_ok_q      <= rearm_ok_d;
			cooldown_done_q <= cooldown_done_d;
		end
	end

	always_comb begin
		inc             = (elapsed_q == CountMax) ? elapsed_q : elapsed_q + 1'b1;
		inc_w           = CmpW'(inc);
		arm_ok_now      = (mode_q == MODE_SLEEP) || rearm_ok_q;
		mode_d          = mode_q;
		elapsed_d       = elapsed_q;
		rearm_ok_d      = rearm_ok_q;
		cooldown_done_d = cooldown_done_q;
		enter           = 1'b0;
		enter_mode      = mode_q;
		res.event_res     = EV_NONE;
		res.power_off_req = 1'b0;

		case (act_t'(item.action))
			ACT_TICK: begin
				elapsed_d = inc;
				case (mode_q)
					MODE_SLEEP: begin
						if (!item.hold_sleep && !item.bench_test &&
								inc_w >= CmpW'(cfg.power_off_ticks)) begin
							res.power_off_req = 1'b1;
							res.event_res     = EV_TIMEOUT;
						end
					end
					MODE_ARMED: begin
						if (inc_w >= CmpW'(cfg.arm_timeout)) begin
							enter         = 1'b1;
							enter_mode    = MODE_SLEEP;
							res.event_res = EV_TIMEOUT;
						end
					end
					MODE_LOGGING: begin
						if (inc_w >= CmpW'(cfg.max_log_ticks)) begin
							enter         = 1'b1;
							enter_mode    = MODE_POSTRUN;
							res.event_res = EV_TIMEOUT;
						end
					end
					default: begin
						if (inc_w >= CmpW'(cfg.cooldown_ticks) && !cooldown_done_q) begin
							cooldown_done_d = 1'b1;
							enter           = 1'b1;
							enter_mode      = MODE_SLEEP;
							res.event_res   = EV_COOLDOWN;
						end
					end
				endcase
			end
			ACT_REQUEST: begin
				if (item.target_mode != mode_q) begin
					if (item.target_mode == MODE_ARMED && !arm_ok_now) begin
						res.event_res = EV_ARM_BLOCKED;
					end else if (item.target_mode == MODE_LOGGING && mode_q != MODE_ARMED) begin
						res.event_res = EV_NOT_ARMED;
					end else if (item.target_mode == MODE_POSTRUN &&
							mode_q != MODE_LOGGING) begin
						res.event_res = EV_NOT_LOGGING;
					end else begin
						enter         = 1'b1;
						enter_mode    = item.target_mode;
						res.event_res = EV_ENTERED;
					end
				end
			end
			ACT_RESTART: begin
				if (mode_q == MODE_SLEEP) begin
					elapsed_d = '0;
				end
			end
			default: ;
		endcase

		// Entering a mode restarts its timer and updates the rearm guard.
		if (enter) begin
			mode_d    = enter_mode;
			elapsed_d = '0;
			if (enter_mode == MODE_SLEEP) begin
				rearm_ok_d = 1'b1;
			end else if (enter_mode == MODE_POSTRUN) begin
				rearm_ok_d      = 1'b0;
				cooldown_done_d = 1'b0;
			end
		end

		res.mode         = mode_d;
		res.prev_mode    = mode_q;
		res.transitioned = enter;
		res.arm_allowed  = (mode_d == MODE_SLEEP) || rearm_ok_d;
	end

endmodule

`default_nettype wire

### hw/rtl/timed_mode_sequencer_unit.sv
// Timed mode sequencer, top level. An item passes the input register, then the
// result register, which presents its result. Throughput: one item per cycle
// unless the result side stalls; the only loop is the update of the mode,
// elapsed counter and rearm flag state. Reset: arst_n clears the pipeline, puts
// the block in sleep with a zero timer and loads the default time limits.
// Depends on tms_pkg, tms_if, tms_cfg_regs and tms_core.
`default_nettype none

module timed_mode_sequencer_unit
	import tms_pkg::*;
#(
	parameter int COUNT_BITS = CountBitsDef
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	tms_in_if.sink                      item,
	tms_out_if.source                   result,
	input  wire logic                   cfg_we,
	input  wire logic [CfgIdxWidth-1:0] cfg_index,
	input  wire logic [CfgWidth-1:0]    cfg_wdata
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_c, res_q;
	logic  valid_q;
	logic  adv_out;
	logic  adv_s1;

	// A transaction moves into the result register when that register is empty
	// or being drained in the same cycle.
	assign adv_out    = valid_s1 && (!valid_q || result.ready);
	assign adv_s1     = !valid_s1 || adv_out;
	assign item.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item.valid) begin
			item_s1.action      <= item.action;
			item_s1.target_mode <= mode_t'(item.target_mode);
			item_s1.hold_sleep  <= item.hold_sleep;
			item_s1.bench_test  <= item.bench_test;
		end
	end

	tms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tms_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_out),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			res_q <= res_c;
		end
	end

	assign result.valid         = valid_q;
	assign result.mode          = res_q.mode;
	assign result.prev_mode     = res_q.prev_mode;
	assign result.transitioned  = res_q.transitioned;
	assign result.event_res     = res_q.event_res;
	assign result.power_off_req = res_q.power_off_req;
	assign result.arm_allowed   = res_q.arm_allowed;

endmodule

`default_nettype wire

### bench/mode_sequence_checker.sv
`timescale 1ns / 1ps
// Checker for the timed mode sequencer. It watches the item, result and register ports,
// keeps its own model of the mode state and compares every result transaction field by field.
// Depends on tms_pkg and tms_if.

module mode_sequence_checker
	import tms_pkg::*;
#(
	parameter int COUNT_BITS = CountBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tms_in_if                      item,
	tms_out_if                     result,
	input  logic                   cfg_we,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgWidth-1:0]    cfg_wdata,
	output int                     report_mismatches,
	output int                     reports_due
);

	mode_t                 cur_mode;
	logic [COUNT_BITS-1:0] elapsed;
	logic                  rearm_ok;
	logic                  cooldown_done;
	logic [CfgWidth-1:0]   arm_lim;
	logic [CfgWidth-1:0]   log_lim;
	logic [CfgWidth-1:0]   cool_lim;
	logic [CfgWidth-1:0]   poff_lim;

	res_t mode_reports_due[$];
	res_t want;
	item_t seen;
	int   mismatches = 0;

	function automatic void enter_mode(input mode_t m);
		cur_mode = m;
		elapsed = '0;
		if (m == MODE_SLEEP) begin
			rearm_ok = 1'b1;
		end else if (m == MODE_POSTRUN) begin
			rearm_ok = 1'b0;
			cooldown_done = 1'b0;
		end
	endfunction

	// Applies one command to the model state and returns the report it should produce.
	function automatic res_t next_mode_report(input item_t c);
		res_t r;
		r.prev_mode = cur_mode;
		r.transitioned = 1'b0;
		r.event_res = EV_NONE;
		r.power_off_req = 1'b0;
		case (c.action)
			ACT_TICK: begin
				if (elapsed != '1)
					elapsed = elapsed + 1'b1;
				case (cur_mode)
					MODE_SLEEP: begin
						if (!c.hold_sleep && !c.bench_test && elapsed >= poff_lim) begin
							r.power_off_req = 1'b1;
							r.event_res = EV_TIMEOUT;
						end
					end
					MODE_ARMED: begin
						if (elapsed >= arm_lim) begin
							enter_mode(MODE_SLEEP);
							r.event_res = EV_TIMEOUT;
							r.transitioned = 1'b1;
						end
					end
					MODE_LOGGING: begin
						if (elapsed >= log_lim) begin
							enter_mode(MODE_POSTRUN);
							r.event_res = EV_TIMEOUT;
							r.transitioned = 1'b1;
						end
					end
					default: begin
						if (elapsed >= cool_lim && !cooldown_done) begin
							cooldown_done = 1'b1;
							enter_mode(MODE_SLEEP);
							r.event_res = EV_COOLDOWN;
							r.transitioned = 1'b1;
						end
					end
				endcase
			end
			ACT_REQUEST: begin
				if (c.target_mode != cur_mode) begin
					if (c.target_mode == MODE_ARMED && !(cur_mode == MODE_SLEEP || rearm_ok))
						r.event_res = EV_ARM_BLOCKED;
					else if (c.target_mode == MODE_LOGGING && cur_mode != MODE_ARMED)
						r.event_res = EV_NOT_ARMED;
					else if (c.target_mode == MODE_POSTRUN && cur_mode != MODE_LOGGING)
						r.event_res = EV_NOT_LOGGING;
					else begin
						enter_mode(c.target_mode);
						r.event_res = EV_ENTERED;
						r.transitioned = 1'b1;
					end
				end
			end
			ACT_RESTART: begin
				if (cur_mode == MODE_SLEEP)
					elapsed = '0;
			end
			default: ;
		endcase
		r.mode = cur_mode;
		r.arm_allowed = (cur_mode == MODE_SLEEP) || rearm_ok;
		return r;
	endfunction

	task automatic check_field(input string field, input int wanted, input int actual);
		if (wanted != actual) begin
			$error("%s: expected %0d, actual %0d", field, wanted, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_SLEEP;
			elapsed = '0;
			rearm_ok = 1'b1;
			cooldown_done = 1'b0;
			arm_lim = ArmTimeoutRst;
			log_lim = MaxLogTicksRst;
			cool_lim = CooldownTicksRst;
			poff_lim = PowerOffTicksRst;
			mode_reports_due.delete();
		end else begin
			// Results are matched before new items are modeled, so a report can never
			// be paired with an item accepted at the same edge.
			if (result.valid && result.ready) begin
				if (mode_reports_due.size() == 0) begin
					$error("result transaction with no report outstanding");
					mismatches++;
				end else begin
					want = mode_reports_due.pop_front();
					check_field("mode", want.mode, result.mode);
					check_field("prev_mode", want.prev_mode, result.prev_mode);
					check_field("transitioned", want.transitioned, result.transitioned);
					check_field("event_res", want.event_res, result.event_res);
					check_field("power_off_req", want.power_off_req, result.power_off_req);
					check_field("arm_allowed", want.arm_allowed, result.arm_allowed);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ARM_TIMEOUT:     arm_lim = cfg_wdata;
					CFG_MAX_LOG_TICKS:   log_lim = cfg_wdata;
					CFG_COOLDOWN_TICKS:  cool_lim = cfg_wdata;
					CFG_POWER_OFF_TICKS: poff_lim = cfg_wdata;
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				seen.action = item.action;
				seen.target_mode = mode_t'(item.target_mode);
				seen.hold_sleep = item.hold_sleep;
				seen.bench_test = item.bench_test;
				mode_reports_due.push_back(next_mode_report(seen));
			end
		end
		report_mismatches <= mismatches;
		reports_due <= mode_reports_due.size();
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the timed mode sequencer bench: clock, reset, register writes, command stimulus
// and result back-pressure. Depends on tms_pkg, tms_if, the sequencer and mode_sequence_checker.

module testbench;
	import tms_pkg::*;

	localparam logic [1:0] ActUnused = 2'd3;
	localparam int PhaseItems = 140;
	localparam int LongHoldCycles = 200;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CfgIdxWidth-1:0] cfg_index;
	logic [CfgWidth-1:0]    cfg_wdata;
	int                     mismatch_total;
	int                     reports_due;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold_req = 1'b0;

	tms_in_if  item_ch ();
	tms_out_if result_ch ();

	timed_mode_sequencer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mode_sequence_checker u_mode_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.item              (item_ch),
		.result            (result_ch),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.report_mismatches (mismatch_total),
		.reports_due       (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Result side: random stalls, or one long hold-off when the stimulus asks for it.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LongHoldCycles) @(posedge clk);
			end else
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic item_t make_command(input logic [1:0] act, input mode_t target,
			input logic hold, input logic test);
		item_t c;
		c.action = act;
		c.target_mode = target;
		c.hold_sleep = hold;
		c.bench_test = test;
		return c;
	endfunction

	function automatic item_t random_command();
		item_t c;
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			c.action = ACT_TICK;
		else if (roll < 90)
			c.action = ACT_REQUEST;
		else if (roll < 97)
			c.action = ACT_RESTART;
		else
			c.action = ActUnused;
		c.target_mode = mode_t'($urandom_range(3));
		c.hold_sleep = ($urandom_range(3) == 0);
		c.bench_test = ($urandom_range(3) == 0);
		return c;
	endfunction

	// Valid is only lowered for a gap or a drain, so back-to-back transactions keep it high.
	task automatic offer_command(input item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= c.action;
		item_ch.target_mode <= c.target_mode;
		item_ch.hold_sleep <= c.hold_sleep;
		item_ch.bench_test <= c.bench_test;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic drain_reports();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_limits(input logic [CfgWidth-1:0] arm, input logic [CfgWidth-1:0] logt,
			input logic [CfgWidth-1:0] cool, input logic [CfgWidth-1:0] poff);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ARM_TIMEOUT;
		cfg_wdata <= arm;
		@(posedge clk);
		cfg_index <= CFG_MAX_LOG_TICKS;
		cfg_wdata <= logt;
		@(posedge clk);
		cfg_index <= CFG_COOLDOWN_TICKS;
		cfg_wdata <= cool;
		@(posedge clk);
		cfg_index <= CFG_POWER_OFF_TICKS;
		cfg_wdata <= poff;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		item_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_TICK;
		item_ch.target_mode = MODE_SLEEP;
		item_ch.hold_sleep = 1'b0;
		item_ch.bench_test = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through every guard, timeout and the power-off hold bits.
		load_limits(32'd3, 32'd3, 32'd2, 32'd2);
		offer_command(make_command(ACT_TICK, MODE_SLEEP, 1'b1, 1'b0));
		offer_command(make_command(ACT_TICK, MODE_SLEEP, 1'b0, 1'b1));
		offer_command(make_command(ACT_TICK, MODE_SLEEP, 1'b0, 1'b0));
		offer_command(make_command(ACT_TICK, MODE_SLEEP, 1'b1, 1'b1));
		offer_command(make_command(ACT_RESTART, MODE_SLEEP, 1'b0, 1'b0));
		offer_command(make_command(ActUnused, MODE_POSTRUN, 1'b1, 1'b1));
		offer_command(make_command(ACT_REQUEST, MODE_SLEEP, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_LOGGING, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_POSTRUN, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_ARMED, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_POSTRUN, 1'b1, 1'b0));
		offer_command(make_command(ACT_RESTART, MODE_ARMED, 1'b0, 1'b0));
		repeat (3) offer_command(make_command(ACT_TICK, MODE_SLEEP, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_ARMED, 1'b0, 1'b1));
		offer_command(make_command(ACT_REQUEST, MODE_LOGGING, 1'b0, 1'b0));
		repeat (3) offer_command(make_command(ACT_TICK, MODE_ARMED, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_ARMED, 1'b0, 1'b0));
		repeat (2) offer_command(make_command(ACT_TICK, MODE_LOGGING, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_ARMED, 1'b1, 1'b1));
		offer_command(make_command(ACT_REQUEST, MODE_LOGGING, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_POSTRUN, 1'b0, 1'b0));
		offer_command(make_command(ACT_REQUEST, MODE_SLEEP, 1'b0, 1'b0));
		drain_reports();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 6)
				0: load_limits(32'd1, 32'd1, 32'd1, 32'd1);
				1: load_limits(32'd5, 32'd8, 32'd4, 32'd12);
				2: load_limits(32'd0, 32'd3, 32'd0, 32'd2);
				3: load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				4: load_limits(32'd3, 32'd20, 32'd6, 32'd40);
				default: load_limits(32'hFFFF_FFFF, 32'd2, 32'd1, 32'hFFFF_FFFF);
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			// The sender keeps offering through this hold-off, so the block fills and stalls.
			if (phase == 0)
				long_hold_req = 1'b1;
			sent = 0;
			while (sent < PhaseItems) begin
				c = random_command();
				offer_command(c);
				if (c.action != ActUnused)
					sent++;
			end
			drain_reports();
		end

		repeat (8) @(posedge clk);
		if (mismatch_total == 0 && reports_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
